// ----- hdl/pat_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional array table package
// Request and status codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned REQ_W   = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_LOAD_HIT,
        CELL_SHIFT_HIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   key;
    } cell_ctrl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ----- hdl/pat_cell.sv -----
// ----------------------------------------------------------------------------
// Positional array table cell
// One table slot: holds a word and a search hit flag, takes data from its
// lower neighbor on insert, from its upper neighbor on delete, and hands
// its hit flag down the chain during a search walk.
// ----------------------------------------------------------------------------
module pat_cell
    import pat_pkg::*;
#(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned IDX   = 0,
    localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [IW-1:0]     slot,
    input  logic [CW-1:0]     count,
    input  logic [WORD_W-1:0] lower_data,
    input  logic [WORD_W-1:0] upper_data,
    input  logic              upper_hit,
    output logic [WORD_W-1:0] data,
    output logic              hit
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              hit_reg;
    logic              hit_next;

    localparam logic [IW-1:0] MY_SLOT  = IW'(IDX);
    localparam logic [CW-1:0] MY_COUNT = CW'(IDX);

    always_comb begin
        data_next = data_reg;
        hit_next  = hit_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (MY_SLOT == slot) begin
                    data_next = ctrl.key;
                end else if (MY_SLOT > slot) begin
                    data_next = lower_data;
                end
            end
            CELL_DELETE: begin
                if (MY_SLOT >= slot) begin
                    data_next = upper_data;
                end
            end
            CELL_LOAD_HIT: begin
                hit_next = (data_reg == ctrl.key) && (MY_COUNT < count);
            end
            CELL_SHIFT_HIT: begin
                hit_next = upper_hit;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

// ----- hdl/positional_array_table_unit.sv -----
// ----------------------------------------------------------------------------
// Positional array table unit
// Ordered table of signed words kept in a chain of cells, with insert,
// delete, first-match search and clear requests.
// ----------------------------------------------------------------------------
//  channel | ports                                         | direction
//  s_      | s_valid s_ready s_req_type s_position s_value | in
//  m_      | m_valid m_ready m_status m_found_position     | out
//          | m_entry_count                                 |
//
//  Insert, delete, clear and search of an empty table are answered from idle.
//  Insert and delete shift the cells from the given position up in parallel.
//  Any other search scans: cells compare in parallel, then hit flags walk down
//  the chain one cell a cycle until cell 0 hits or the last entry is reached.
//  Reset clears the count and controller; stored words need no clearing.
//  A stalled result holds the controller; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module positional_array_table_unit
    import pat_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [WORD_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic [POS_W-1:0]         m_found_position,
    output logic [POS_W-1:0]         m_entry_count
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      scan_reg;
    logic [CW-1:0]      scan_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [STAT_W-1:0]  m_status_reg;
    logic [POS_W-1:0]   m_found_reg;
    logic [POS_W-1:0]   m_count_reg;

    cell_ctrl_t         cell_ctrl;
    logic [IW-1:0]      slot;
    logic [WORD_W-1:0]  cell_data [DEPTH];
    logic               cell_hit  [DEPTH];

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [STAT_W-1:0]  res_status;
    logic [POS_W-1:0]   res_found;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      count_ext;
    logic               is_full;
    logic               ins_ok;
    logic               del_ok;
    logic               scan_last;
    logic               scan_done;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;

    assign pos_ext   = PW'(s_position);
    assign count_ext = PW'(count_reg);
    assign is_full   = (count_reg >= FULL_COUNT);
    assign ins_ok    = (pos_ext != '0) && (pos_ext <= count_ext + PW'(1));
    assign del_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
    assign slot      = IW'(pos_ext - PW'(1));
    assign scan_last = (scan_reg == count_reg - CW'(1));
    assign scan_done = cell_hit[0] || scan_last;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_req_type == REQ_SEARCH) && (count_reg != '0)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cell_ctrl.op  = CELL_HOLD;
        cell_ctrl.key = s_value;
        count_next    = count_reg;
        scan_next     = scan_reg;
        out_load      = 1'b0;
        res_status    = ST_OK;
        res_found     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_INSERT: begin
                            out_load = 1'b1;
                            if (is_full) begin
                                res_status = ST_FULL;
                            end else if (!ins_ok) begin
                                res_status = ST_INVALID;
                            end else begin
                                cell_ctrl.op = CELL_INSERT;
                                count_next   = count_reg + CW'(1);
                            end
                        end
                        REQ_DELETE: begin
                            out_load = 1'b1;
                            if (count_reg == '0) begin
                                res_status = ST_EMPTY;
                            end else if (!del_ok) begin
                                res_status = ST_INVALID;
                            end else begin
                                cell_ctrl.op = CELL_DELETE;
                                count_next   = count_reg - CW'(1);
                            end
                        end
                        REQ_SEARCH: begin
                            if (count_reg == '0) begin
                                out_load   = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                cell_ctrl.op = CELL_LOAD_HIT;
                                scan_next    = '0;
                            end
                        end
                        REQ_CLEAR: begin
                            out_load   = 1'b1;
                            count_next = '0;
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        if (cell_hit[0]) begin
                            res_found = POS_W'(scan_reg + CW'(1));
                        end else begin
                            res_status = ST_NOT_FOUND;
                        end
                    end
                end else begin
                    cell_ctrl.op = CELL_SHIFT_HIT;
                    scan_next    = scan_reg + CW'(1);
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status;
            m_found_reg  <= res_found;
            m_count_reg  <= POS_W'(count_next);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] lower_data;
        logic [WORD_W-1:0] upper_data;
        logic              upper_hit;

        if (g == 0) begin : g_first
            assign lower_data = cell_data[g];
        end else begin : g_mid_lo
            assign lower_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign upper_data = cell_data[g];
            assign upper_hit  = 1'b0;
        end else begin : g_mid_hi
            assign upper_data = cell_data[g+1];
            assign upper_hit  = cell_hit[g+1];
        end

        pat_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .slot       (slot),
            .count      (count_reg),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .upper_hit  (upper_hit),
            .data       (cell_data[g]),
            .hit        (cell_hit[g])
        );
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_entry_count    = m_count_reg;

endmodule

// ----- tb/positional_array_table_unit_test.sv -----
// ----------------------------------------------------------------------------
// Positional array table unit testbench
// Drives insert, delete, search and clear requests in random bursts, keeps
// its own ordered copy of the table to work out each reply, and checks every
// reply beat field by field while the reply side stalls on its own pattern.
// ----------------------------------------------------------------------------
module positional_array_table_unit_test;
    import pat_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 128;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          PENDING_MAX  = 4;
    localparam int          SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam longint      CYCLE_LIMIT  = 1000000;
    localparam int          HOLD_AFTER   = 150;
    localparam int          HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [REQ_W-1:0]         kind;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] word;
    } table_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  found_pos;
        logic [POS_W-1:0]  count;
    } table_reply_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [REQ_W-1:0]         s_req_type = REQ_CLEAR;
    logic [POS_W-1:0]         s_position = '0;
    logic signed [WORD_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [STAT_W-1:0]        m_status;
    logic [POS_W-1:0]         m_found_position;
    logic [POS_W-1:0]         m_entry_count;

    table_req_t               req_pending[$];
    table_reply_t             replies_due[$];
    logic signed [WORD_W-1:0] words_q[$];

    int     mismatches = 0;
    int     reqs_issued = 0;
    int     replies_seen = 0;
    int     peak_fill = 0;
    int     kind_seen[0:3] = '{0, 0, 0, 0};
    int     status_seen[0:7] = '{0, 0, 0, 0, 0, 0, 0, 0};
    longint cycles = 0;

    positional_array_table_unit #(
        .DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint want_v,
                                   input longint got_v);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH cycle %0d beat %0d: %s expected %0d got %0d",
                     cycles, replies_seen, what, want_v, got_v);
    endtask

    // Apply one accepted request to the table copy and return its reply.
    function automatic table_reply_t predict_request(input logic [REQ_W-1:0] kind,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [WORD_W-1:0] key);
        table_reply_t res;
        int           n;
        int           i;
        bit           hit;
        res.status    = ST_OK;
        res.found_pos = '0;
        n = words_q.size();
        case (kind)
            REQ_INSERT: begin
                if (n >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else if (pos == 0 || int'(pos) > n + 1) begin
                    res.status = ST_INVALID;
                end else begin
                    words_q.insert(int'(pos) - 1, key);
                end
            end
            REQ_DELETE: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos == 0 || int'(pos) > n) begin
                    res.status = ST_INVALID;
                end else begin
                    words_q.delete(int'(pos) - 1);
                end
            end
            REQ_SEARCH: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    hit = 1'b0;
                    res.status = ST_NOT_FOUND;
                    for (i = 0; i < n && !hit; i++) begin
                        if (words_q[i] == key) begin
                            hit = 1'b1;
                            res.status = ST_OK;
                            res.found_pos = POS_W'(i + 1);
                        end
                    end
                end
            end
            default: begin
                words_q.delete();
            end
        endcase
        if (words_q.size() > peak_fill)
            peak_fill = words_q.size();
        res.count = POS_W'(words_q.size());
        return res;
    endfunction

    // Sender: bursts of random length with random gaps.
    always @(posedge aclk) begin : drive_requests
        table_req_t r;
        int         burst_left;
        int         gap_left;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (req_pending.size() > 0) begin
                r = req_pending.pop_front();
                s_valid    <= 1'b1;
                s_req_type <= r.kind;
                s_position <= r.pos;
                s_value    <= r.word;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 7))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(7, 40);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Predict on each request beat, check each reply beat, stall the reply side.
    always @(posedge aclk) begin : watch_ports
        table_reply_t want;
        int           pattern_cyc;
        int           hold_left;
        bit           hold_done;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            pattern_cyc = 0;
            hold_left   = 0;
            hold_done   = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                replies_due.push_back(predict_request(s_req_type, s_position, s_value));
                kind_seen[s_req_type]++;
            end
            if (m_valid && m_ready) begin
                replies_seen++;
                status_seen[m_status]++;
                if (replies_due.size() == 0) begin
                    report_mismatch("reply with no request outstanding, status", 0, m_status);
                end else begin
                    want = replies_due.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", want.status, m_status);
                    if (m_found_position !== want.found_pos)
                        report_mismatch("found_position", want.found_pos, m_found_position);
                    if (m_entry_count !== want.count)
                        report_mismatch("entry_count", want.count, m_entry_count);
                end
            end
            pattern_cyc++;
            if (!hold_done && replies_seen >= HOLD_AFTER && s_valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (pattern_cyc[8:7])
                    2'd0:    m_ready <= 1'b1;
                    2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
                    2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (pattern_cyc[1:0] != 2'b11);
                endcase
            end
        end
    end

    task automatic queue_req(input logic [REQ_W-1:0] kind, input int pos,
                             input logic signed [WORD_W-1:0] word);
        table_req_t r;
        while (req_pending.size() >= PENDING_MAX)
            @(negedge aclk);
        r.kind = kind;
        r.pos  = POS_W'(pos);
        r.word = word;
        req_pending.push_back(r);
        reqs_issued++;
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || s_valid || replies_due.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh0000_0000;
                    1:       return -32'sd1;
                    2:       return 32'sh7FFF_FFFF;
                    default: return 32'sh8000_0000;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] search_key();
        int n;
        n = words_q.size();
        if (n > 0 && $urandom_range(0, 3) != 0)
            return words_q[$urandom_range(0, n - 1)];
        return rand_word();
    endfunction

    initial begin : stimulus
        int base;
        int n;
        int k;
        int pick;
        int burst_len;

        // Empty table, bad positions, edge words, first match, clear.
        queue_req(REQ_DELETE, 1, 32'sd0);
        queue_req(REQ_SEARCH, 0, 32'sd0);
        queue_req(REQ_INSERT, 0, 32'sd5);
        queue_req(REQ_INSERT, 2, 32'sd5);
        queue_req(REQ_INSERT, 1, 32'sh7FFF_FFFF);
        queue_req(REQ_INSERT, 2, 32'sh8000_0000);
        queue_req(REQ_INSERT, 1, -32'sd1);
        queue_req(REQ_INSERT, 2, 32'sd7);
        queue_req(REQ_INSERT, 5, 32'sd7);
        queue_req(REQ_INSERT, 7, 32'sd9);
        queue_req(REQ_INSERT, 128, 32'sd0);
        queue_req(REQ_SEARCH, 99, 32'sd7);
        queue_req(REQ_SEARCH, 0, 32'sh8000_0000);
        queue_req(REQ_SEARCH, 128, -32'sd1);
        queue_req(REQ_SEARCH, 3, 32'sd0);
        queue_req(REQ_DELETE, 0, 32'sd0);
        queue_req(REQ_DELETE, 6, 32'sd0);
        queue_req(REQ_DELETE, 128, 32'sd0);
        queue_req(REQ_DELETE, 2, -32'sd1);
        queue_req(REQ_DELETE, 4, 32'sh7FFF_FFFF);
        queue_req(REQ_SEARCH, 1, 32'sd7);
        queue_req(REQ_CLEAR, 77, $urandom);
        queue_req(REQ_SEARCH, 0, -32'sd1);
        queue_req(REQ_DELETE, 1, 32'sd0);
        wait_drained();

        base = reqs_issued;
        while (reqs_issued - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 3) begin
                // Fill to the top, knock on the full table, then trim.
                wait_drained();
                n = words_q.size();
                while (n < TABLE_DEPTH) begin
                    queue_req(REQ_INSERT, $urandom_range(1, n + 1), rand_word());
                    n++;
                end
                repeat ($urandom_range(2, 5))
                    queue_req(REQ_INSERT, $urandom_range(0, 128), rand_word());
                repeat ($urandom_range(4, 10))
                    queue_req(REQ_SEARCH, $urandom_range(0, 128), search_key());
                repeat ($urandom_range(5, 40)) begin
                    queue_req(REQ_DELETE, $urandom_range(1, n), rand_word());
                    n--;
                end
            end else begin
                burst_len = $urandom_range(40, 80);
                for (k = 0; k < burst_len; k++) begin
                    n = words_q.size();
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        if (n >= TABLE_DEPTH || $urandom_range(0, 7) == 0)
                            queue_req(REQ_INSERT, $urandom_range(0, 128), rand_word());
                        else
                            queue_req(REQ_INSERT, $urandom_range(1, n + 1), rand_word());
                    end else if (pick < 65) begin
                        if (n == 0 || $urandom_range(0, 7) == 0)
                            queue_req(REQ_DELETE, $urandom_range(0, 128), rand_word());
                        else
                            queue_req(REQ_DELETE, $urandom_range(1, n), rand_word());
                    end else if (pick < 97) begin
                        queue_req(REQ_SEARCH, $urandom_range(0, 128), search_key());
                    end else begin
                        queue_req(REQ_CLEAR, $urandom_range(0, 128), rand_word());
                    end
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d requests: %0d insert, %0d delete, %0d search, %0d clear; table peaked at %0d of %0d",
                 reqs_issued, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 peak_fill, TABLE_DEPTH);
        $display("Replies: ok %0d, full %0d, empty %0d, bad position %0d, miss %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pat_pkg.sv
hdl/pat_cell.sv
hdl/positional_array_table_unit.sv
tb/positional_array_table_unit_test.sv
